>>> hw/rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg: shared constants and types of the centred moving average
// Default sizes, the span register's format and the back-end state type.
// ----------------------------------------------------------------------------
package cma_pkg;

	// Largest half-width of the averaging window.
	localparam int MAX_HALF = 15;
	// Width of one signed sample.
	localparam int SAMPLE_BITS = 16;
	// Width and reset value of the span register.
	localparam int SPAN_BITS = 5;
	localparam logic [SPAN_BITS-1:0] SPAN_RESET = 5'd5;
	// Number of jobs that the queue between front and back can hold.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_READ,
		B_DRAIN,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

>>> hw/rtl/cma_in_if.sv
// ----------------------------------------------------------------------------
// cma_in_if: sample channel
// Valid/ready channel that carries one sample and its end-of-sequence flag.
// ----------------------------------------------------------------------------
interface cma_in_if #(
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          final_sample;

	modport source (output valid, output sample, output final_sample, input ready);
	modport sink (input valid, input sample, input final_sample, output ready);
endinterface

>>> hw/rtl/cma_out_if.sv
// ----------------------------------------------------------------------------
// cma_out_if: average channel
// Valid/ready channel that carries one window mean and its end-of-sequence flag.
// ----------------------------------------------------------------------------
interface cma_out_if #(
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          final_average;

	modport source (output valid, output average, output final_average, input ready);
	modport sink (input valid, input average, input final_average, output ready);
endinterface

>>> hw/rtl/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module cma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/cma_queue.sv
// ----------------------------------------------------------------------------
// cma_queue: job queue between front and back
// A small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cma_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cma_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/cma_front.sv
// ----------------------------------------------------------------------------
// cma_front: sample intake and job classification
// Holds the span register, stores each sample in the history ring and works
// out how many averages the sample releases, then queues that as a job.
// ----------------------------------------------------------------------------
module cma_front #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS,
	localparam int CNT_W = $clog2(MAX_HALF + 2),
	localparam int HALF_W = (MAX_HALF > 1) ? $clog2(MAX_HALF + 1) : 1,
	localparam int RING_AW = $clog2(2 * MAX_HALF + 2 + cma_pkg::QUEUE_DEPTH),
	localparam int JOB_W = RING_AW + 3 * CNT_W + HALF_W + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             span_we,
	input  logic [cma_pkg::SPAN_BITS-1:0]    span_wdata,
	cma_in_if.sink                           samples,
	input  logic                             q_full,
	output logic                             q_push,
	output logic [JOB_W-1:0]                 job,
	output logic                             ram_we,
	output logic [RING_AW-1:0]               ram_waddr,
	output logic [SAMPLE_BITS-1:0]           ram_wdata
);

	localparam int HCW = (HALF_W > 4) ? HALF_W : 4;

	typedef struct packed {
		logic [RING_AW-1:0] ptr;
		logic [CNT_W-1:0]   pend;
		logic [CNT_W-1:0]   recv;
		logic [CNT_W-1:0]   count;
		logic [HALF_W-1:0]  half;
		logic               last;
	} job_t;

	logic [cma_pkg::SPAN_BITS-1:0] span_q;
	logic [RING_AW-1:0]            wr_ptr_q;
	logic [CNT_W-1:0]              pend_q;
	logic [CNT_W-1:0]              recv_q;

	logic                          accept;
	logic [cma_pkg::SPAN_BITS-1:0] span_m1;
	logic [HCW-1:0]                half_wide;
	logic [HALF_W-1:0]             half;
	logic [CNT_W-1:0]              half_c;
	logic [CNT_W-1:0]              pend_inc;
	logic [CNT_W-1:0]              release_n;
	logic [CNT_W:0]                recv_sum;
	logic [CNT_W-1:0]              recv_next;
	job_t                          job_s;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = !q_full;

	// An even span acts as one less; span zero acts as span one.
	assign span_m1   = span_q - 1'b1;
	assign half_wide = (span_q == '0) ? '0 : HCW'(span_m1[cma_pkg::SPAN_BITS-1:1]);
	assign half      = (half_wide > HCW'(MAX_HALF)) ? HALF_W'(MAX_HALF) : HALF_W'(half_wide);
	assign half_c    = CNT_W'(half);

	always_comb begin
		pend_inc = (pend_q < CNT_W'(MAX_HALF + 1)) ? pend_q + 1'b1 : pend_q;
		if (samples.final_sample) begin
			release_n = pend_inc;
		end else if (pend_inc > half_c) begin
			release_n = pend_inc - half_c;
		end else begin
			release_n = '0;
		end
		recv_sum  = (CNT_W + 1)'(recv_q) + (CNT_W + 1)'(release_n);
		recv_next = (recv_sum > (CNT_W + 1)'(MAX_HALF)) ? CNT_W'(MAX_HALF) : recv_sum[CNT_W-1:0];
	end

	// Every sample queues a job, even one that releases nothing, so that the
	// write pointer can never run further ahead of the back end than the queue.
	always_comb begin
		job_s.ptr   = wr_ptr_q;
		job_s.pend  = pend_inc;
		job_s.recv  = recv_q;
		job_s.count = release_n;
		job_s.half  = half;
		job_s.last  = samples.final_sample;
	end

	assign job       = job_s;
	assign q_push    = accept;
	assign ram_we    = accept;
	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = samples.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= cma_pkg::SPAN_RESET;
			wr_ptr_q <= '0;
			pend_q   <= '0;
			recv_q   <= '0;
		end else begin
			if (span_we) begin
				span_q <= span_wdata;
			end
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (samples.final_sample) begin
					pend_q <= '0;
					recv_q <= '0;
				end else begin
					pend_q <= pend_inc - release_n;
					recv_q <= recv_next;
				end
			end
		end
	end

endmodule

>>> hw/rtl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div: signed by unsigned restoring divider
// Divides a signed window sum by the window length, one quotient bit per
// cycle, and truncates the quotient toward zero.
// ----------------------------------------------------------------------------
module cma_div #(
	parameter int SUM_W = 21,
	parameter int DIV_W = 5,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SUM_W-1:0]       dividend,
	input  logic [DIV_W-1:0]       divisor,
	output logic                   done,
	output logic [SAMPLE_BITS-1:0] quotient
);

	localparam int CW = $clog2(SUM_W + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic [SUM_W-1:0]       quo_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       den_q;

	logic [SUM_W-1:0]       magnitude;
	logic [DIV_W:0]         trial;
	logic [DIV_W:0]         diff;
	logic                   fits;
	logic [SAMPLE_BITS-1:0] quo_mag;

	assign magnitude = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign diff      = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});
	assign quo_mag   = quo_q[SAMPLE_BITS-1:0];
	assign quotient  = neg_q ? (~quo_mag + 1'b1) : quo_mag;
	assign done      = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= magnitude;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> hw/rtl/cma_back.sv
// ----------------------------------------------------------------------------
// cma_back: window summation and averaging
// Takes jobs from the queue and, for each average a job releases, reads the
// window from the history ring, sums it, divides it and presents the result.
// ----------------------------------------------------------------------------
module cma_back #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS,
	localparam int CNT_W = $clog2(MAX_HALF + 2),
	localparam int HALF_W = (MAX_HALF > 1) ? $clog2(MAX_HALF + 1) : 1,
	localparam int RING_AW = $clog2(2 * MAX_HALF + 2 + cma_pkg::QUEUE_DEPTH),
	localparam int JOB_W = RING_AW + 3 * CNT_W + HALF_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  logic [JOB_W-1:0]       q_head,
	output logic                   q_pop,
	output logic [RING_AW-1:0]     ram_raddr,
	input  logic [SAMPLE_BITS-1:0] ram_rdata,
	cma_out_if.source              averages
);

	localparam int OFF_W = $clog2(2 * MAX_HALF + 1);
	localparam int DIV_W = $clog2(2 * MAX_HALF + 2);
	localparam int SUM_W = SAMPLE_BITS + OFF_W;

	typedef struct packed {
		logic [RING_AW-1:0] ptr;
		logic [CNT_W-1:0]   pend;
		logic [CNT_W-1:0]   recv;
		logic [CNT_W-1:0]   count;
		logic [HALF_W-1:0]  half;
		logic               last;
	} job_t;

	cma_pkg::back_state_t state_q;
	cma_pkg::back_state_t state_d;

	job_t                   head;
	logic [RING_AW-1:0]     ptr_q;
	logic [HALF_W-1:0]      half_q;
	logic                   last_q;
	logic [CNT_W-1:0]       left_q;
	logic [CNT_W-1:0]       pend_q;
	logic [CNT_W-1:0]       recv_q;
	logic [OFF_W-1:0]       off_q;
	logic [OFF_W-1:0]       rd_cnt_q;
	logic [DIV_W-1:0]       den_q;
	logic signed [SUM_W-1:0] acc_q;
	logic                   rd_valid_s1;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] average_q;
	logic                   final_q;

	logic                   load_job;
	logic                   setup;
	logic                   rd_issue;
	logic                   div_start;
	logic                   out_load;
	logic                   div_done;
	logic [SAMPLE_BITS-1:0] div_quotient;

	logic [CNT_W-1:0]       half_c;
	logic [CNT_W-1:0]       pend_m1;
	logic [CNT_W-1:0]       d_recv;
	logic [CNT_W-1:0]       d;
	logic signed [SUM_W-1:0] rd_ext;
	logic signed [SUM_W-1:0] sum_next;

	assign head = q_head;

	// Half-width of the window for the oldest pending average. After the last
	// sample of a sequence it also shrinks towards the end of the sequence.
	assign half_c  = CNT_W'(half_q);
	assign pend_m1 = pend_q - 1'b1;
	assign d_recv  = (recv_q < half_c) ? recv_q : half_c;
	assign d       = (last_q && (pend_m1 < d_recv)) ? pend_m1 : d_recv;

	assign rd_ext   = SUM_W'(signed'(ram_rdata));
	assign sum_next = rd_valid_s1 ? acc_q + rd_ext : acc_q;
	assign ram_raddr = ptr_q - RING_AW'(off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cma_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		load_job  = 1'b0;
		setup     = 1'b0;
		rd_issue  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			cma_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					load_job = 1'b1;
					state_d  = (head.count == '0) ? cma_pkg::B_IDLE : cma_pkg::B_START;
				end
			end
			cma_pkg::B_START: begin
				setup   = 1'b1;
				state_d = cma_pkg::B_READ;
			end
			cma_pkg::B_READ: begin
				rd_issue = 1'b1;
				if (rd_cnt_q == '0) begin
					state_d = cma_pkg::B_DRAIN;
				end
			end
			cma_pkg::B_DRAIN: begin
				div_start = 1'b1;
				state_d   = cma_pkg::B_DIV;
			end
			cma_pkg::B_DIV: begin
				if (div_done) begin
					state_d = cma_pkg::B_OUT;
				end
			end
			cma_pkg::B_OUT: begin
				if (!out_valid_q || averages.ready) begin
					out_load = 1'b1;
					state_d  = (left_q == CNT_W'(1)) ? cma_pkg::B_IDLE : cma_pkg::B_START;
				end
			end
			default: begin
				state_d = cma_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			ptr_q  <= head.ptr;
			half_q <= head.half;
			last_q <= head.last;
			left_q <= head.count;
			pend_q <= head.pend;
			recv_q <= head.recv;
		end
		if (setup) begin
			// Reads run from the oldest sample of the window to the newest.
			off_q    <= OFF_W'(pend_m1) + OFF_W'(d);
			rd_cnt_q <= OFF_W'(d) << 1;
			den_q    <= (DIV_W'(d) << 1) + DIV_W'(1);
			acc_q    <= '0;
		end else begin
			acc_q <= sum_next;
		end
		if (rd_issue) begin
			off_q    <= off_q - 1'b1;
			rd_cnt_q <= rd_cnt_q - 1'b1;
		end
		if (out_load) begin
			average_q <= div_quotient;
			final_q   <= last_q && (left_q == CNT_W'(1));
			left_q    <= left_q - 1'b1;
			pend_q    <= pend_m1;
			recv_q    <= (recv_q < CNT_W'(MAX_HALF)) ? recv_q + 1'b1 : recv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign averages.valid         = out_valid_q;
	assign averages.average       = average_q;
	assign averages.final_average = final_q;

	cma_div #(
		.SUM_W       (SUM_W),
		.DIV_W       (DIV_W),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

endmodule

>>> hw/rtl/centered_moving_average.sv
// ----------------------------------------------------------------------------
// centered_moving_average: streaming centred moving average
// Each average is the truncated mean of the samples from d before to d after
// its own, with d shrinking towards either end of a sequence.
// An input sample is accepted whenever the job queue has room.
// Each average takes 2d+1 history reads through the one-read-per-cycle history
// port and then a pass through the bit-serial divider.
// Reset clears the sequence counters, the queue and the output; span returns to 5.
// ----------------------------------------------------------------------------
module centered_moving_average #(
	parameter int MAX_HALF = cma_pkg::MAX_HALF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          span_we,
	input  logic [cma_pkg::SPAN_BITS-1:0] span_wdata,
	cma_in_if.sink                        samples,
	cma_out_if.source                     averages
);

	localparam int CNT_W = $clog2(MAX_HALF + 2);
	localparam int HALF_W = (MAX_HALF > 1) ? $clog2(MAX_HALF + 1) : 1;
	localparam int RING_AW = $clog2(2 * MAX_HALF + 2 + cma_pkg::QUEUE_DEPTH);
	localparam int JOB_W = RING_AW + 3 * CNT_W + HALF_W + 1;

	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [JOB_W-1:0]       job;
	logic [JOB_W-1:0]       q_head;
	logic                   ram_we;
	logic [RING_AW-1:0]     ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic [RING_AW-1:0]     ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	cma_front #(
		.MAX_HALF    (MAX_HALF),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.span_we    (span_we),
		.span_wdata (span_wdata),
		.samples    (samples),
		.q_full     (q_full),
		.q_push     (q_push),
		.job        (job),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	cma_queue #(
		.WIDTH (JOB_W),
		.DEPTH (cma_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (job),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// The ring is sized so that samples queued ahead never overwrite a window
	// that the back end is still reading.
	cma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (2 ** RING_AW)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cma_back #(
		.MAX_HALF    (MAX_HALF),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.averages  (averages)
	);

endmodule
